/* sv/hle_pkg.sv */
package hle_pkg;

  // command codes carried in in_tuser
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // decoded item as it travels from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] idx;
    logic       in_range;
    logic [3:0] la;
    logic [3:0] ra;
    logic [3:0] count;
  } op_t;

  // one word of the label memory; marks are used only while renumbering
  typedef struct packed {
    logic        mark_l;
    logic        mark_r;
    logic [31:0] left;
    logic [31:0] right;
  } lbl_word_t;

endpackage

/* sv/haplotype_label_encoder.sv */
// channel  dir  handshake              payload
// in       in   in_tvalid / in_tready  in_tdata (index, alleles, count), in_tuser (command)
// out      out  out_tvalid/out_tready  out_tdata (left, right, leaf count)
// cfg      in   cfg_valid / cfg_ready  cfg_data (collapse_missing)
//
// After reset the label memory is cleared before the first item is taken.
// Start and load finish in idle; read fetches the label word, then forms the result;
// add locus walks the label memory.
// A renumbering clears the 2^(clog2(2*SAMPLES+1)+1) map slots, then reads each sample,
// looks up both labels in the map and writes it back, then walks again to place the last leaf.
// A 4-deep queue keeps input open while the back end is busy or the result waits.
module haplotype_label_encoder #(
  parameter int SAMPLES    = 1024,
  parameter int MAX_LEAVES = 16777216
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample_index, l_code, r_code, allele_count
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // left_label, right_label, leaf_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data
);
  import hle_pkg::*;

  logic collapse_r;
  logic q_full, q_push, q_valid, q_pop;
  op_t  q_in, q_out;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) collapse_r <= 1'b0;
    else if (cfg_valid) collapse_r <= cfg_data[0];
  end

  hle_front #(.SAMPLES(SAMPLES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_full(q_full), .q_push(q_push), .q_op(q_in)
  );

  hle_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_op(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_op(q_out)
  );

  hle_back #(.SAMPLES(SAMPLES), .MAX_LEAVES(MAX_LEAVES)) u_back (
    .clk(clk), .rst_n(rst_n), .collapse(collapse_r),
    .op_valid(q_valid), .op(q_out), .op_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

/* sv/hle_front.sv */
module hle_front #(
  parameter int SAMPLES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         q_full,
  output logic         q_push,
  output hle_pkg::op_t q_op
);
  import hle_pkg::*;

  logic [31:0] idx32;

  // accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // classify: unpack fields and check the sample range once, here
  assign idx32 = {22'd0, in_tdata[9:0]};
  always_comb begin
    q_op.cmd      = in_tuser;
    q_op.idx      = in_tdata[9:0];
    q_op.in_range = (idx32 < 32'(SAMPLES));
    q_op.la       = in_tdata[13:10];
    q_op.ra       = in_tdata[17:14];
    q_op.count    = in_tdata[21:18];
  end

  // range flag agrees with the index; upper pad bits carry nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_op.in_range == (32'(q_op.idx) < 32'(SAMPLES))))
    else $error("range flag does not match index");

endmodule

/* sv/hle_queue.sv */
module hle_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  hle_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output hle_pkg::op_t pop_op
);
  import hle_pkg::*;

  op_t            ent_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign valid  = (cnt_r != '0);
  assign pop_op = ent_r[rp_r];

  // pointer and fill update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_op;
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue fill beyond depth");

endmodule

/* sv/hle_back.sv */
module hle_back #(
  parameter int SAMPLES    = 1024,
  parameter int MAX_LEAVES = 16777216
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         collapse,
  input  logic         op_valid,
  input  hle_pkg::op_t op,
  output logic         op_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata
);
  import hle_pkg::*;

  localparam int AW       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int NLW      = $clog2(2 * SAMPLES + 1);
  localparam int HTW      = NLW + 1;
  localparam int HT_DEPTH = 1 << HTW;
  localparam logic [AW-1:0]  LAST    = AW'(SAMPLES - 1);
  localparam logic [HTW-1:0] HT_LAST = HTW'(HT_DEPTH - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLR    = 4'd1;
  localparam logic [3:0] ST_WALK   = 4'd2;
  localparam logic [3:0] ST_RD     = 4'd3;
  localparam logic [3:0] ST_RN_CLR = 4'd4;
  localparam logic [3:0] ST_P1_RD  = 4'd5;
  localparam logic [3:0] ST_P1_KEY = 4'd6;
  localparam logic [3:0] ST_P1_CMP = 4'd7;
  localparam logic [3:0] ST_P1_WR  = 4'd8;

  typedef struct packed {
    logic            v;
    logic [31:0]     key;
    logic [NLW-1:0]  val;
  } ht_ent_t;

  // memories
  lbl_word_t lbl_mem [SAMPLES];
  logic [7:0] gen_mem [SAMPLES];
  ht_ent_t   ht_mem  [HT_DEPTH];

  lbl_word_t lbl_rd_r, lbl_wd;
  logic [7:0] gen_rd_r, gen_wd;
  ht_ent_t   ht_rd_r, ht_wd;
  logic      lbl_we, lbl_re, gen_we, gen_re, ht_we, ht_re;
  logic [AW-1:0]  lbl_wa, lbl_ra, gen_wa;
  logic [HTW-1:0] ht_wa, ht_ra;

  // control state
  logic [3:0]     state_r, state_nxt;
  logic [31:0]    leaves_r, leaves_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt, pa_r, pa_nxt;
  logic           iss_r, iss_nxt, pv_r, pv_nxt;
  logic           mode_add_r, mode_add_nxt;
  logic [3:0]     count_r, count_nxt;
  logic [NLW-1:0] nl_r, nl_nxt;
  logic           half_r, half_nxt;
  logic [HTW-1:0] probe_r, probe_nxt, hcnt_r, hcnt_nxt;
  logic [NLW-1:0] resl_r, resl_nxt, resr_r, resr_nxt;
  logic           markl_r, markl_nxt, markr_r, markr_nxt;
  logic           rng_r, rng_nxt;
  logic           out_v_r, out_v_nxt;
  logic [95:0]    out_d_r, out_d_nxt;

  // walk arithmetic
  logic [4:0]  mult;
  logic [3:0]  wla, wra;
  logic [31:0] last_old, prod_leaves, lmul, rmul;
  logic        miss;
  lbl_word_t   walk_wd;

  // renumbering lookup
  logic [31:0]    key, key_sh;
  logic [HTW-1:0] hash;
  logic [31:0]    op_idx32;
  logic [AW-1:0]  op_addr;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  assign op_idx32 = 32'(op.idx);
  assign op_addr  = op_idx32[AW-1:0];

  assign mult        = {1'b0, count_r} + 5'd1;
  assign wla         = gen_rd_r[7:4];
  assign wra         = gen_rd_r[3:0];
  assign last_old    = leaves_r - 32'd1;
  assign prod_leaves = 32'(leaves_r * mult);
  assign lmul        = 32'(lbl_rd_r.left * mult);
  assign rmul        = 32'(lbl_rd_r.right * mult);
  assign miss        = (wla == count_r) || (wra == count_r);

  // write data of one walk step: locus extension or final mark fill
  always_comb begin
    walk_wd        = lbl_rd_r;
    walk_wd.mark_l = 1'b0;
    walk_wd.mark_r = 1'b0;
    if (mode_add_r) begin
      if (leaves_r == 32'd1) begin
        walk_wd.left  = {28'd0, wla};
        walk_wd.right = {28'd0, wra};
        if (collapse && miss) begin
          walk_wd.left  = {28'd0, count_r};
          walk_wd.right = {28'd0, count_r};
        end
      end else if (collapse && (lbl_rd_r.left == last_old ||
                                lbl_rd_r.right == last_old || miss)) begin
        walk_wd.left  = prod_leaves - 32'd1;
        walk_wd.right = prod_leaves - 32'd1;
      end else begin
        walk_wd.left  = lmul + {28'd0, wla};
        walk_wd.right = rmul + {28'd0, wra};
      end
    end else begin
      if (lbl_rd_r.mark_l) walk_wd.left  = 32'(nl_r);
      if (lbl_rd_r.mark_r) walk_wd.right = 32'(nl_r);
    end
  end

  // key of the current half and its home slot
  assign key    = half_r ? lbl_rd_r.right : lbl_rd_r.left;
  assign key_sh = key >> HTW;
  assign hash   = key[HTW-1:0] ^ key_sh[HTW-1:0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    leaves_nxt   = leaves_r;
    cnt_nxt      = cnt_r;
    pa_nxt       = pa_r;
    iss_nxt      = iss_r;
    pv_nxt       = 1'b0;
    mode_add_nxt = mode_add_r;
    count_nxt    = count_r;
    nl_nxt       = nl_r;
    half_nxt     = half_r;
    probe_nxt    = probe_r;
    hcnt_nxt     = hcnt_r;
    resl_nxt     = resl_r;
    resr_nxt     = resr_r;
    markl_nxt    = markl_r;
    markr_nxt    = markr_r;
    rng_nxt      = rng_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_d_nxt    = out_d_r;
    op_pop       = 1'b0;
    lbl_we = 1'b0; lbl_wa = cnt_r; lbl_wd = '0;
    lbl_re = 1'b0; lbl_ra = cnt_r;
    gen_we = 1'b0; gen_wa = op_addr; gen_wd = {op.la, op.ra};
    gen_re = 1'b0;
    ht_we  = 1'b0; ht_wa = probe_r; ht_wd = '0;
    ht_re  = 1'b0; ht_ra = hash;

    unique case (state_r)
      ST_CLR: begin
        lbl_we = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (op_valid && (op.cmd != CMD_READ || !out_v_r)) begin
          op_pop = 1'b1;
          unique case (op.cmd)
            CMD_START: leaves_nxt = 32'd1;
            CMD_LOAD:  gen_we = op.in_range;
            CMD_ADD: begin
              count_nxt    = op.count;
              mode_add_nxt = 1'b1;
              cnt_nxt      = '0;
              iss_nxt      = 1'b1;
              state_nxt    = ST_WALK;
            end
            CMD_READ: begin
              lbl_re    = 1'b1;
              lbl_ra    = op_addr;
              rng_nxt   = op.in_range;
              state_nxt = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        out_v_nxt = 1'b1;
        out_d_nxt = {leaves_r,
                     rng_r ? lbl_rd_r.right : 32'd0,
                     rng_r ? lbl_rd_r.left  : 32'd0};
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        // issue reads one sample ahead of the write-back
        if (iss_r) begin
          lbl_re = 1'b1;
          gen_re = 1'b1;
          pv_nxt = 1'b1;
          pa_nxt = cnt_r;
          if (cnt_r == LAST) iss_nxt = 1'b0;
          else cnt_nxt = cnt_r + 1'b1;
        end
        if (pv_r) begin
          lbl_we = 1'b1;
          lbl_wa = pa_r;
          lbl_wd = walk_wd;
          if (pa_r == LAST) begin
            pv_nxt = 1'b0;
            if (mode_add_r) begin
              leaves_nxt = prod_leaves;
              if (prod_leaves >= 32'(MAX_LEAVES)) begin
                hcnt_nxt  = '0;
                state_nxt = ST_RN_CLR;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else begin
              leaves_nxt = 32'(nl_r) + 32'd1;
              state_nxt  = ST_IDLE;
            end
          end
        end
      end
      ST_RN_CLR: begin
        ht_we = 1'b1;
        ht_wa = hcnt_r;
        if (hcnt_r == HT_LAST) begin
          cnt_nxt   = '0;
          nl_nxt    = '0;
          state_nxt = ST_P1_RD;
        end else begin
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      ST_P1_RD: begin
        lbl_re    = 1'b1;
        half_nxt  = 1'b0;
        state_nxt = ST_P1_KEY;
      end
      ST_P1_KEY: begin
        if (key == last_old) begin
          // last leaf: filled in after the pass
          if (half_r) markr_nxt = 1'b1; else markl_nxt = 1'b1;
          half_nxt  = 1'b1;
          state_nxt = half_r ? ST_P1_WR : ST_P1_KEY;
        end else begin
          if (half_r) markr_nxt = 1'b0; else markl_nxt = 1'b0;
          ht_re     = 1'b1;
          probe_nxt = hash;
          state_nxt = ST_P1_CMP;
        end
      end
      ST_P1_CMP: begin
        if (!ht_rd_r.v || ht_rd_r.key == key) begin
          // empty slot inserts the next dense label, a hit reuses its label
          if (!ht_rd_r.v) begin
            ht_we  = 1'b1;
            ht_wd  = '{v: 1'b1, key: key, val: nl_r};
            nl_nxt = nl_r + 1'b1;
            if (half_r) resr_nxt = nl_r; else resl_nxt = nl_r;
          end else begin
            if (half_r) resr_nxt = ht_rd_r.val; else resl_nxt = ht_rd_r.val;
          end
          half_nxt  = 1'b1;
          state_nxt = half_r ? ST_P1_WR : ST_P1_KEY;
        end else begin
          probe_nxt = probe_r + 1'b1;
          ht_re     = 1'b1;
          ht_ra     = probe_r + 1'b1;
        end
      end
      ST_P1_WR: begin
        lbl_we = 1'b1;
        lbl_wd = '{mark_l: markl_r, mark_r: markr_r,
                   left: 32'(resl_r), right: 32'(resr_r)};
        if (cnt_r == LAST) begin
          mode_add_nxt = 1'b0;
          cnt_nxt      = '0;
          iss_nxt      = 1'b1;
          state_nxt    = ST_WALK;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_P1_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      leaves_r <= 32'd1;
      cnt_r    <= '0;
      iss_r    <= 1'b0;
      pv_r     <= 1'b0;
      nl_r     <= '0;
      hcnt_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      leaves_r <= leaves_nxt;
      cnt_r    <= cnt_nxt;
      iss_r    <= iss_nxt;
      pv_r     <= pv_nxt;
      nl_r     <= nl_nxt;
      hcnt_r   <= hcnt_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    mode_add_r <= mode_add_nxt;
    count_r    <= count_nxt;
    half_r     <= half_nxt;
    probe_r    <= probe_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
    markl_r    <= markl_nxt;
    markr_r    <= markr_nxt;
    rng_r      <= rng_nxt;
    out_d_r    <= out_d_nxt;
  end

  // label memory
  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (lbl_re) lbl_rd_r <= lbl_mem[lbl_ra];
  end

  // genotype memory
  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_wa] <= gen_wd;
    if (gen_re) gen_rd_r <= gen_mem[lbl_ra];
  end

  // renumbering map, open addressing with linear probing
  always_ff @(posedge clk) begin
    if (ht_we) ht_mem[ht_wa] <= ht_wd;
    if (ht_re) ht_rd_r <= ht_mem[ht_ra];
  end

  assert property (@(posedge clk) disable iff (!rst_n) op_pop |-> state_r == ST_IDLE)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_RD |-> !out_v_r)
    else $error("read result would overwrite pending result");
  assert property (@(posedge clk) disable iff (!rst_n) leaves_r != 32'd0)
    else $error("leaf count is zero");

endmodule
